// ===== hdl/hcb_pkg.sv =====
package hcb_pkg;
	localparam int MaxSymbols = 64;
	localparam int NodeCap = 2 * MaxSymbols - 1;
	localparam int NodeW = $clog2(NodeCap + 1);
	localparam int SymW = 8;
	localparam int SymAw = $clog2(MaxSymbols);
	localparam int FreqW = 16;
	localparam int WeightW = 22;
	localparam int LenW = 6;
	localparam int CodeW = 63;
	localparam int StackCap = MaxSymbols;
	localparam int StkAw = $clog2(StackCap);
	localparam int SpW = $clog2(StackCap + 1);
	localparam int InDataW = 24;
	localparam int OutDataW = 80;
endpackage

// ===== hdl/huffman_code_builder.sv =====
// Huffman code builder. Load (symbol, frequency) beats, one per cycle, up to 64
// leaves; symbol 0 and beats beyond capacity are dropped. The beat with tlast set
// starts the build: one shared min-scan unit reads one node weight per cycle from
// a registered-read store. Each merge runs two scans over the stored nodes, one
// for each of the two lightest live nodes, then the merge step; merges repeat
// until one live node is left, and a final scan finds it as the root. A
// left-first preorder walk follows: each node visit passes through a fetch and
// a decide state, each leaf then holds its code beat until m_tready takes it,
// and each return to a pending right branch passes through a pop state.
// m_tlast marks the last leaf. s_tready is low from the cycle after the tlast
// beat until the cycle after the final code beat is taken; a tlast beat with no
// stored leaves gives no beats.
module huffman_code_builder (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [hcb_pkg::InDataW-1:0] s_tdata, // symbol[7:0], frequency[23:8]
	input  logic s_tlast,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [hcb_pkg::OutDataW-1:0] m_tdata, // out_symbol, code_length, code_bits, pad
	output logic m_tlast
);
	import hcb_pkg::*;

	typedef enum logic [7:0] {
		ST_LOAD  = 8'b00000001,
		ST_SCANA = 8'b00000010,
		ST_SCANB = 8'b00000100,
		ST_MERGE = 8'b00001000,
		ST_FETCH = 8'b00010000,
		ST_VISIT = 8'b00100000,
		ST_EMIT  = 8'b01000000,
		ST_POP   = 8'b10000000
	} state_t;

	state_t state_q;
	logic [WeightW-1:0] weight_q [NodeCap];
	logic [NodeW-1:0] left_q [NodeCap];
	logic [NodeW-1:0] right_q [NodeCap];
	logic [SymW-1:0] sym_q [MaxSymbols];
	logic [NodeW-1:0] stk_node_q [StackCap];
	logic [LenW-1:0] stk_len_q [StackCap];
	logic [CodeW-1:0] stk_bits_q [StackCap];

	logic [WeightW-1:0] scan_w_s1;
	logic [NodeW-1:0] rd_left_q, rd_right_q;
	logic [SymW-1:0] rd_sym_q;
	logic [NodeW-1:0] pop_node_q;
	logic [LenW-1:0] pop_len_q;
	logic [CodeW-1:0] pop_bits_q;

	logic [NodeCap-1:0] live_q;
	logic [NodeW-1:0] leaves_q, total_q, live_cnt_q, idx_q, a_q, b_q, best_idx_q, cur_q;
	logic [NodeW-1:0] scan_idx_s1;
	logic scan_vld_s1, best_ok_q;
	logic [WeightW-1:0] best_w_q, wa_q, sum_q;
	logic [LenW-1:0] cur_len_q;
	logic [CodeW-1:0] cur_bits_q;
	logic [SpW-1:0] sp_q;
	logic [SymW-1:0] o_sym_q;
	logic [LenW-1:0] o_len_q;
	logic [CodeW-1:0] o_bits_q;
	logic o_last_q;

	logic [SymW-1:0] in_sym;
	logic [FreqW-1:0] in_freq;
	logic s_hs, load_ok, scanning, scan_hit, scan_last;
	logic [NodeW-1:0] leaves_nxt, pick_idx;
	logic [WeightW-1:0] pick_w;
	logic [SpW-1:0] sp_dec;

	assign in_sym = s_tdata[SymW-1:0];
	assign in_freq = s_tdata[SymW+FreqW-1:SymW];
	assign s_tready = (state_q == ST_LOAD);
	assign s_hs = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tdata = {3'b000, o_bits_q, o_len_q, o_sym_q};
	assign m_tlast = o_last_q;

	// Shared min-scan compare on the registered weight: strict less keeps the lowest
	// index on ties.
	always_comb begin
		load_ok = s_hs && in_sym != '0 && leaves_q < NodeW'(MaxSymbols);
		leaves_nxt = load_ok ? leaves_q + 1'b1 : leaves_q;
		scanning = (state_q == ST_SCANA) || (state_q == ST_SCANB);
		scan_hit = scan_vld_s1 && live_q[scan_idx_s1] &&
			!(state_q == ST_SCANB && scan_idx_s1 == a_q) &&
			(!best_ok_q || scan_w_s1 < best_w_q);
		scan_last = scan_vld_s1 && (scan_idx_s1 == total_q - 1'b1);
		pick_idx = scan_hit ? scan_idx_s1 : best_idx_q;
		pick_w = scan_hit ? scan_w_s1 : best_w_q;
		sp_dec = sp_q - 1'b1;
	end

	// Node and stack storage, written one entry at a time and read through registers.
	always_ff @(posedge clk) begin
		if (load_ok) begin
			weight_q[leaves_q] <= WeightW'(in_freq);
			sym_q[leaves_q[SymAw-1:0]] <= in_sym;
		end else if (state_q == ST_MERGE) begin
			weight_q[total_q] <= sum_q;
			left_q[total_q] <= a_q;
			right_q[total_q] <= b_q;
		end
		if (state_q == ST_VISIT && cur_q >= leaves_q) begin
			stk_node_q[sp_q[StkAw-1:0]] <= rd_right_q;
			stk_len_q[sp_q[StkAw-1:0]] <= cur_len_q + 1'b1;
			stk_bits_q[sp_q[StkAw-1:0]] <= {cur_bits_q[CodeW-2:0], 1'b1};
		end
		scan_w_s1 <= weight_q[idx_q];
		rd_left_q <= left_q[cur_q];
		rd_right_q <= right_q[cur_q];
		rd_sym_q <= sym_q[cur_q[SymAw-1:0]];
		pop_node_q <= stk_node_q[sp_dec[StkAw-1:0]];
		pop_len_q <= stk_len_q[sp_dec[StkAw-1:0]];
		pop_bits_q <= stk_bits_q[sp_dec[StkAw-1:0]];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			live_q <= '0;
			leaves_q <= '0;
			total_q <= '0;
			live_cnt_q <= '0;
			idx_q <= '0;
			a_q <= '0;
			b_q <= '0;
			best_idx_q <= '0;
			best_ok_q <= 1'b0;
			best_w_q <= '0;
			wa_q <= '0;
			sum_q <= '0;
			scan_idx_s1 <= '0;
			scan_vld_s1 <= 1'b0;
			cur_q <= '0;
			cur_len_q <= '0;
			cur_bits_q <= '0;
			sp_q <= '0;
			o_sym_q <= '0;
			o_len_q <= '0;
			o_bits_q <= '0;
			o_last_q <= 1'b0;
		end else begin
			scan_idx_s1 <= idx_q;
			scan_vld_s1 <= scanning && !scan_last;
			unique case (state_q)
				ST_LOAD: begin
					if (s_hs) begin
						if (load_ok) live_q <= live_q | (NodeCap'(1) << leaves_q);
						leaves_q <= leaves_nxt;
						if (s_tlast) begin
							total_q <= leaves_nxt;
							live_cnt_q <= leaves_nxt;
							idx_q <= '0;
							best_ok_q <= 1'b0;
							if (leaves_nxt != '0) state_q <= ST_SCANA;
						end
					end
				end
				ST_SCANA: begin
					if (scan_last) begin
						idx_q <= '0;
						best_ok_q <= 1'b0;
						a_q <= pick_idx;
						wa_q <= pick_w;
						if (live_cnt_q < NodeW'(2)) begin
							cur_q <= pick_idx;
							cur_len_q <= '0;
							cur_bits_q <= '0;
							sp_q <= '0;
							state_q <= ST_FETCH;
						end else state_q <= ST_SCANB;
					end else begin
						if (idx_q != total_q - 1'b1) idx_q <= idx_q + 1'b1;
						if (scan_hit) begin
							best_idx_q <= scan_idx_s1;
							best_w_q <= scan_w_s1;
							best_ok_q <= 1'b1;
						end
					end
				end
				ST_SCANB: begin
					if (scan_last) begin
						idx_q <= '0;
						best_ok_q <= 1'b0;
						b_q <= pick_idx;
						sum_q <= wa_q + pick_w;
						state_q <= ST_MERGE;
					end else begin
						if (idx_q != total_q - 1'b1) idx_q <= idx_q + 1'b1;
						if (scan_hit) begin
							best_idx_q <= scan_idx_s1;
							best_w_q <= scan_w_s1;
							best_ok_q <= 1'b1;
						end
					end
				end
				ST_MERGE: begin
					live_q <= (live_q & ~(NodeCap'(1) << a_q) & ~(NodeCap'(1) << b_q)) |
						(NodeCap'(1) << total_q);
					total_q <= total_q + 1'b1;
					live_cnt_q <= live_cnt_q - 1'b1;
					state_q <= ST_SCANA;
				end
				ST_FETCH: begin
					state_q <= ST_VISIT;
				end
				ST_VISIT: begin
					if (cur_q < leaves_q) begin
						o_sym_q <= rd_sym_q;
						o_len_q <= cur_len_q;
						o_bits_q <= cur_bits_q;
						o_last_q <= (sp_q == '0);
						state_q <= ST_EMIT;
					end else begin
						// The right child waits on the stack; the left child is visited next.
						sp_q <= sp_q + 1'b1;
						cur_q <= rd_left_q;
						cur_len_q <= cur_len_q + 1'b1;
						cur_bits_q <= {cur_bits_q[CodeW-2:0], 1'b0};
						state_q <= ST_FETCH;
					end
				end
				ST_EMIT: begin
					if (m_tready) begin
						if (sp_q == '0) begin
							live_q <= '0;
							leaves_q <= '0;
							state_q <= ST_LOAD;
						end else begin
							sp_q <= sp_dec;
							state_q <= ST_POP;
						end
					end
				end
				ST_POP: begin
					cur_q <= pop_node_q;
					cur_len_q <= pop_len_q;
					cur_bits_q <= pop_bits_q;
					state_q <= ST_FETCH;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("input ready while a code is pending");
	a_two_picks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MERGE |-> a_q != b_q) else $error("merge picked one node twice");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(o_bits_q))
		else $error("code beat changed while stalled");
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SpW'(StackCap)) else $error("walk stack overflow");
endmodule
